FILE: rtl/ebd_pkg.sv
// escape byte decoder package: decode phase type, character codes and helpers
// no dependencies; used by ebd_decode and escape_byte_decoder_unit
package ebd_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  // c - 'a' + 10 folds into a single offset
  localparam logic [7:0] HEX_ALPHA_OFS = 8'h57;

  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LF    = 8'h0A;

  typedef enum logic [3:0] {
    PH_TEXT = 4'b0001,  // normal text
    PH_ESC  = 4'b0010,  // after backslash
    PH_HEX1 = 4'b0100,  // after \x, waiting for first hex char
    PH_HEX2 = 4'b1000   // first hex char held
  } ebd_phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } ebd_result_t;

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c inside {[CH_0:CH_9]}) begin
      v = c - CH_0;
    end else begin
      v = c - HEX_ALPHA_OFS;
    end
    return v;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      CH_S:    v = BYTE_SPACE;
      CH_T:    v = BYTE_TAB;
      CH_R:    v = BYTE_CR;
      CH_N:    v = BYTE_LF;
      default: v = c;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/ebd_decode.sv
// escape byte decoder: combinational decode of one byte against the current phase
// depends on ebd_pkg
module ebd_decode (
  input  ebd_pkg::ebd_phase_t  phase,
  input  logic [3:0]           hi_nib,
  input  logic [7:0]           byte_in,
  input  logic                 last_in,
  output ebd_pkg::ebd_result_t res,
  output ebd_pkg::ebd_phase_t  phase_nxt,
  output logic [3:0]           hi_nib_nxt
);
  import ebd_pkg::*;

  ebd_phase_t ph_eff;
  logic [7:0] hv;

  assign hv = hex_value(byte_in);

  always_comb begin
    // \x with only one byte left: that byte is plain text
    ph_eff = ((phase == PH_HEX1) && last_in) ? PH_TEXT : phase;
    res.valid  = 1'b0;
    res.data   = 8'h00;
    res.last   = last_in;
    phase_nxt  = PH_TEXT;
    hi_nib_nxt = hi_nib;
    case (ph_eff)
      PH_TEXT: begin
        if (byte_in != CH_BSLASH) begin
          res.valid = 1'b1;
          res.data  = byte_in;
        end else if (last_in) begin
          res.valid = 1'b1;
        end else begin
          phase_nxt = PH_ESC;
        end
      end
      PH_ESC: begin
        if (byte_in == CH_X) begin
          phase_nxt = PH_HEX1;
        end else begin
          res.valid = 1'b1;
          res.data  = escape_map(byte_in);
        end
      end
      PH_HEX1: begin
        hi_nib_nxt = hv[3:0];
        phase_nxt  = PH_HEX2;
      end
      PH_HEX2: begin
        res.valid = 1'b1;
        res.data  = {hi_nib, 4'h0} + hv;
      end
      default: begin
        phase_nxt = PH_TEXT;
      end
    endcase
    if (last_in) begin
      phase_nxt = PH_TEXT;
    end
  end

endmodule

FILE: rtl/escape_byte_decoder_unit.sv
// escape byte decoder top level: input register, decode, result register
// depends on ebd_pkg and ebd_decode
//
// usage:
//   the input stream carries one escaped byte per beat on in_tdata, with
//   in_tlast on the final byte of a message. every input beat yields exactly
//   one output beat: out_tdata holds the decoded byte, out_tuser[0] says
//   whether a decoded byte is present (0 for the backslash and x of an escape
//   and for the first hex char), out_tlast copies the input's last flag.
//   out_tdata is zero when out_tuser[0] is low.
//   an input beat passes through the input register and then the result
//   register. throughput is one beat per cycle while out_tready stays high;
//   the decode phase and the held hex nibble are updated as a beat
//   moves into the result register, so the next byte decodes right behind it.
//   when the receiver drops out_tready the result register holds, the input
//   register fills, and in_tready falls only once both are occupied; no beat
//   is lost or repeated.
//   a synchronous low rst_n empties both registers and returns the decoder to
//   normal text; in_tlast also returns it to normal text at every message end.
module escape_byte_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [0:0] out_tuser,  // [0] out_valid
  output logic       out_tlast   // out_last
);
  import ebd_pkg::*;

  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic        out_v_r;
  ebd_result_t out_res_r;
  ebd_phase_t  phase_r;
  logic [3:0]  hi_nib_r;

  ebd_result_t res_nxt;
  ebd_phase_t  phase_nxt;
  logic [3:0]  hi_nib_nxt;
  logic        out_free;
  logic        adv;
  logic        in_take;

  assign out_free  = !out_v_r || out_tready;
  assign adv       = in_v_r && out_free;
  assign in_tready = !in_v_r || out_free;
  assign in_take   = in_tvalid && in_tready;

  ebd_decode u_decode (
    .phase      (phase_r),
    .hi_nib     (hi_nib_r),
    .byte_in    (in_byte_r),
    .last_in    (in_last_r),
    .res        (res_nxt),
    .phase_nxt  (phase_nxt),
    .hi_nib_nxt (hi_nib_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      phase_r  <= PH_TEXT;
      hi_nib_r <= 4'h0;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r  <= 1'b1;
        phase_r  <= phase_nxt;
        hi_nib_r <= hi_nib_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_res_r.data;
  assign out_tuser[0] = out_res_r.valid;
  assign out_tlast    = out_res_r.last;

endmodule

FILE: tb/tb_escape_byte_decoder_unit.sv
`timescale 1ns / 100ps
// testbench for escape_byte_decoder_unit: directed and random escaped messages,
// with an in-bench decode predictor and a result checker; depends on ebd_pkg
module tb_escape_byte_decoder_unit;
  import ebd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam logic [7:0] CH_A_LOWER = 8'h61;
  localparam logic [7:0] CH_Q = 8'h71;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [0:0] out_tuser;
  logic       out_tlast;

  ebd_result_t pending_decodes[$];
  ebd_phase_t  model_phase = PH_TEXT;
  logic [7:0]  model_hi_nibble = 8'h00;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          sender_idles = 1'b1;

  escape_byte_decoder_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [7:0] hex_digit_worth(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) begin
      return c - CH_0;
    end
    return c - CH_A_LOWER + 8'd10;
  endfunction

  // advances the predicted decoder state by one input byte
  function automatic ebd_result_t predict_decode(input logic [7:0] c, input logic last);
    ebd_result_t res;
    ebd_phase_t  ph;
    res = '0;
    res.last = last;
    ph = model_phase;
    // an x with only one byte after it: that byte is plain text
    if (ph == PH_HEX1 && last) ph = PH_TEXT;
    case (ph)
      PH_TEXT: begin
        if (c != CH_BSLASH) begin
          res.valid = 1'b1;
          res.data = c;
        end else if (last) begin
          res.valid = 1'b1;
        end else begin
          model_phase = PH_ESC;
        end
      end
      PH_ESC: begin
        if (c == CH_X) begin
          model_phase = PH_HEX1;
        end else begin
          res.valid = 1'b1;
          case (c)
            CH_S:    res.data = BYTE_SPACE;
            CH_T:    res.data = BYTE_TAB;
            CH_R:    res.data = BYTE_CR;
            CH_N:    res.data = BYTE_LF;
            default: res.data = c;
          endcase
          model_phase = PH_TEXT;
        end
      end
      PH_HEX1: begin
        model_hi_nibble = hex_digit_worth(c);
        model_phase = PH_HEX2;
      end
      default: begin
        res.valid = 1'b1;
        res.data = {model_hi_nibble[3:0], 4'h0} + hex_digit_worth(c);
        model_phase = PH_TEXT;
      end
    endcase
    if (last) model_phase = PH_TEXT;
    return res;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    ebd_result_t expected;
    if (sender_idles && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = b;
    in_tlast = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected = predict_decode(b, last);
    pending_decodes = {pending_decodes, expected};
    items_sent++;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_hex_char();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 10) return CH_0 + 8'(r);
    return CH_A_LOWER + 8'(r - 10);
  endfunction

  function automatic logic [7:0] pick_pair_char();
    if ($urandom_range(0, 9) < 7) return pick_hex_char();
    return 8'($urandom_range(0, 255));
  endfunction

  // receiver: switches between free flow, light, periodic and heavy stalls
  int unsigned ready_mode = 0;
  int unsigned ready_left = 0;
  int unsigned ready_tick = 0;
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(10, 200);
    end
    ready_left--;
    ready_tick++;
    case (ready_mode)
      0:       out_tready = 1'b1;
      1:       out_tready = ($urandom_range(0, 3) != 0);
      2:       out_tready = ((ready_tick % 5) > 1);
      default: out_tready = ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    ebd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_decodes.size() == 0) begin
        $display("%0t: unexpected beat tuser %0b tdata %02h tlast %0b",
                 $time, out_tuser[0], out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        want = pending_decodes.pop_front();
        if (out_tuser[0] !== want.valid) begin
          $display("%0t: out_tuser[0] expected %0b actual %0b", $time, want.valid, out_tuser[0]);
          mismatch_count++;
        end
        if (out_tdata !== want.data) begin
          $display("%0t: out_tdata expected %02h actual %02h", $time, want.data, out_tdata);
          mismatch_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: out_tlast expected %0b actual %0b", $time, want.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_plain_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_named_escapes();
    logic [7:0] esc_chars [6];
    esc_chars = '{CH_S, CH_T, CH_R, CH_N, CH_BSLASH, CH_Q};
    for (int i = 0; i < 6; i++) begin
      send_byte(CH_BSLASH, 1'b0);
      send_byte(esc_chars[i], i == 5);
    end
  endtask

  task automatic test_hex_pairs();
    // upper-case and non-hex chars take the c - 'a' + 10 value
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_X, 1'b0);
    send_byte(8'h46, 1'b0);
    send_byte(8'h7A, 1'b1);
  endtask

  task automatic test_message_ends();
    send_byte(CH_BSLASH, 1'b1);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_X, 1'b1);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_X, 1'b0);
    send_byte(CH_BSLASH, 1'b1);
  endtask

  task automatic send_random_message();
    logic [7:0]  msg[$];
    int unsigned ntok;
    int unsigned kind;
    ntok = $urandom_range(1, 12);
    for (int t = 0; t < ntok; t++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        msg = {msg, 8'($urandom_range(0, 255))};
      end else if (kind < 55) begin
        msg = {msg, CH_BSLASH};
        case ($urandom_range(0, 4))
          0:       msg = {msg, CH_S};
          1:       msg = {msg, CH_T};
          2:       msg = {msg, CH_R};
          3:       msg = {msg, CH_N};
          default: msg = {msg, CH_BSLASH};
        endcase
      end else if (kind < 65) begin
        msg = {msg, CH_BSLASH};
        msg = {msg, 8'($urandom_range(0, 255))};
      end else if (kind < 92) begin
        msg = {msg, CH_BSLASH};
        msg = {msg, CH_X};
        msg = {msg, pick_pair_char()};
        msg = {msg, pick_pair_char()};
      end else begin
        // possibly broken escape closing the message
        msg = {msg, CH_BSLASH};
        if ($urandom_range(0, 2) != 0) msg = {msg, CH_X};
        if ($urandom_range(0, 1) != 0) msg = {msg, 8'($urandom_range(0, 255))};
        break;
      end
    end
    for (int i = 0; i < msg.size(); i++) begin
      send_byte(msg[i], i == msg.size() - 1);
    end
  endtask

  task automatic test_random_messages(input int unsigned target);
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) sender_idles = !sender_idles;
      send_random_message();
    end
  endtask

  task automatic test_pause_until_drained();
    wait_for_drain();
    repeat ($urandom_range(1, 5)) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_plain_extremes();
    test_named_escapes();
    test_hex_pairs();
    test_message_ends();
    test_random_messages(RANDOM_ITEMS / 2);
    test_pause_until_drained();
    test_random_messages(RANDOM_ITEMS);

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
